// ----- src/pfba_pkg.sv -----
// Package for the page frame bitmap allocator: sizes, codes, state and command types.
// Used by every module of the block; it depends on nothing.
package pfba_pkg;

   localparam int FRAME_WORDS   = 1024;
   localparam int BITS_PER_WORD = 64;
   localparam int BIT_W         = $clog2(BITS_PER_WORD);
   localparam int WORD_AW       = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam int unsigned TOTAL_FRAMES = FRAME_WORDS * BITS_PER_WORD;
   // The search covers frames below 65536 so that the grant fits 16 bits.
   localparam int SEARCH_WORDS  = (FRAME_WORDS < 1024) ? FRAME_WORDS : 1024;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam int OPCODE_W = 3;
   localparam int FRAME_W  = 16;
   localparam int COUNT_W  = 17;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [COUNT_W-1:0] MEM_PAGES_RESET = 17'h10000;
   localparam logic [BITS_PER_WORD-1:0] ALL_ONES = {BITS_PER_WORD{1'b1}};

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_MEMORY_PAGES = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOCK      = 3'd0,
      OP_UNLOCK    = 3'd1,
      OP_RESERVE   = 3'd2,
      OP_UNRESERVE = 3'd3,
      OP_REQUEST   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      K_NOP,
      K_SET,
      K_CLR,
      K_REQ
   } kind_type;

   typedef enum logic [2:0] {
      CNT_NONE,
      CNT_LOCK,
      CNT_UNLOCK,
      CNT_RESV,
      CNT_UNRESV,
      CNT_REQ
   } cnt_type;

   typedef struct packed {
      kind_type           kind;
      cnt_type            cnt;
      logic [COUNT_W-1:0] count;
      logic [WORD_AW-1:0] first_word;
      logic [WORD_AW-1:0] last_word;
      logic [BIT_W-1:0]   first_bit;
      logic [BIT_W-1:0]   last_bit;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN_READ,
      ST_RUN_WRITE,
      ST_SRCH_READ,
      ST_SRCH_CHECK,
      ST_FINISH
   } state_type;

endpackage

// ----- src/pfba_front.sv -----
// Front end: takes request words and turns each into a command for the back end.
// Depends on pfba_pkg; feeds pfba_queue.
module pfba_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfba_pkg::REQ_DATA_W-1:0]   req_tdata,  // start_frame, page_count
   input  logic [pfba_pkg::OPCODE_W-1:0]     req_tuser,  // opcode
   input  logic                              q_full,
   input  logic                              clear_busy,
   output logic                              q_push,
   output pfba_pkg::cmd_type                 q_cmd
);

   logic [pfba_pkg::FRAME_W-1:0] start;
   logic [pfba_pkg::COUNT_W-1:0] count;
   logic [17:0]                  end_sum;
   logic [31:0]                  end_clip;
   logic                         run_ok;

   assign start      = req_tdata[15:0];
   assign count      = req_tdata[32:16];
   assign req_tready = !q_full && !clear_busy;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      end_sum  = {2'b00, start} + {1'b0, count} - 18'd1;
      run_ok   = (count != '0) && (32'(start) < pfba_pkg::TOTAL_FRAMES);
      // Frames past the store move the counters but touch no bit.
      end_clip = (32'(end_sum) > pfba_pkg::TOTAL_FRAMES - 1) ?
                 pfba_pkg::TOTAL_FRAMES - 1 : 32'(end_sum);

      q_cmd.count      = count;
      q_cmd.first_word = pfba_pkg::WORD_AW'(start >> pfba_pkg::BIT_W);
      q_cmd.last_word  = pfba_pkg::WORD_AW'(end_clip >> pfba_pkg::BIT_W);
      q_cmd.first_bit  = start[pfba_pkg::BIT_W-1:0];
      q_cmd.last_bit   = end_clip[pfba_pkg::BIT_W-1:0];

      unique case (req_tuser)
         pfba_pkg::OP_LOCK: begin
            q_cmd.kind = run_ok ? pfba_pkg::K_SET : pfba_pkg::K_NOP;
            q_cmd.cnt  = pfba_pkg::CNT_LOCK;
         end
         pfba_pkg::OP_UNLOCK: begin
            q_cmd.kind = run_ok ? pfba_pkg::K_CLR : pfba_pkg::K_NOP;
            q_cmd.cnt  = pfba_pkg::CNT_UNLOCK;
         end
         pfba_pkg::OP_RESERVE: begin
            q_cmd.kind = run_ok ? pfba_pkg::K_SET : pfba_pkg::K_NOP;
            q_cmd.cnt  = pfba_pkg::CNT_RESV;
         end
         pfba_pkg::OP_UNRESERVE: begin
            q_cmd.kind = run_ok ? pfba_pkg::K_CLR : pfba_pkg::K_NOP;
            q_cmd.cnt  = pfba_pkg::CNT_UNRESV;
         end
         pfba_pkg::OP_REQUEST: begin
            q_cmd.kind = pfba_pkg::K_REQ;
            q_cmd.cnt  = pfba_pkg::CNT_REQ;
         end
         default: begin
            q_cmd.kind = pfba_pkg::K_NOP;
            q_cmd.cnt  = pfba_pkg::CNT_NONE;
         end
      endcase
   end

endmodule

// ----- src/pfba_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on pfba_pkg for the command type and depth.
module pfba_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pfba_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output pfba_pkg::cmd_type  pop_cmd,
   output logic               not_empty
);

   pfba_pkg::cmd_type              entry_ff [pfba_pkg::QUEUE_DEPTH];
   logic [pfba_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pfba_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pfba_pkg::QPTR_W:0]      fill_ff, fill_in;

   assign full      = (fill_ff == (pfba_pkg::QPTR_W+1)'(pfba_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pfba_pkg::QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + pfba_pkg::QPTR_W'(pop);
      fill_in   = fill_ff + (pfba_pkg::QPTR_W+1)'(push) - (pfba_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/pfba_back.sv -----
// Back end: frame bitmap memory, clearing pass, run writer, first-free search and counters.
// Depends on pfba_pkg; takes commands from pfba_queue and drives the result register.
module pfba_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pfba_pkg::COUNT_W-1:0]      memory_pages,
   input  logic                              q_valid,
   input  pfba_pkg::cmd_type                 q_cmd,
   output logic                              q_pop,
   output logic                              clear_busy,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfba_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // granted, free, used, reserved
   output logic                              rsp_tuser   // full_res
);

   localparam int W = pfba_pkg::BITS_PER_WORD;
   localparam int CW = pfba_pkg::COUNT_W;
   localparam logic [pfba_pkg::WORD_AW-1:0] LAST_WORD =
      pfba_pkg::WORD_AW'(pfba_pkg::FRAME_WORDS - 1);
   localparam logic [pfba_pkg::WORD_AW-1:0] SRCH_LAST =
      pfba_pkg::WORD_AW'(pfba_pkg::SEARCH_WORDS - 1);

   logic [W-1:0] mem [pfba_pkg::FRAME_WORDS];
   logic [W-1:0] rdata_ff;
   logic         mem_we;
   logic [W-1:0] mem_wdata;

   pfba_pkg::state_type          state_ff, state_in;
   pfba_pkg::cmd_type            cmd_ff, cmd_in;
   logic [pfba_pkg::WORD_AW-1:0] word_ff, word_in;
   logic [pfba_pkg::FRAME_W-1:0] granted_ff, granted_in;
   logic                         found_ff, found_in;
   logic                         full_ff, full_in;
   logic [CW-1:0]                free_ff, free_in;
   logic [CW-1:0]                used_ff, used_in;
   logic [CW-1:0]                resv_ff, resv_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pfba_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_full_ff, rsp_full_in;

   logic [pfba_pkg::BIT_W-1:0]   lo_bit, hi_bit, free_bit;
   logic [W-1:0]                 run_mask;

   function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] c, input logic [CW-1:0] n);
      return (n >= c) ? '0 : (c - n);
   endfunction

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c, input logic [CW-1:0] n,
                                             input logic [CW-1:0] top);
      logic [CW:0] s;
      s = {1'b0, c} + {1'b0, n};
      if (c >= top) begin
         return c;
      end
      return (s > {1'b0, top}) ? top : s[CW-1:0];
   endfunction

   assign clear_busy = (state_ff == pfba_pkg::ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_full_ff;

   // Edge bits of the run inside the current word; inner words take the whole word.
   always_comb begin
      lo_bit   = (word_ff == cmd_ff.first_word) ? cmd_ff.first_bit : '0;
      hi_bit   = (word_ff == cmd_ff.last_word) ? cmd_ff.last_bit : '1;
      run_mask = (pfba_pkg::ALL_ONES << lo_bit) &
                 (pfba_pkg::ALL_ONES >> (pfba_pkg::BIT_W'(W - 1) - hi_bit));
   end

   always_comb begin
      free_bit = '0;
      for (int b = W - 1; b >= 0; b--) begin
         if (!rdata_ff[b]) begin
            free_bit = pfba_pkg::BIT_W'(b);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      word_in      = word_ff;
      granted_in   = granted_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      free_in      = free_ff;
      used_in      = used_ff;
      resv_in      = resv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_full_in  = rsp_full_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = '0;

      unique case (state_ff)
         pfba_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            word_in = word_ff + 1'b1;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = pfba_pkg::ST_IDLE;
            end
         end
         pfba_pkg::ST_IDLE: begin
            // A new command starts only once the previous result has left.
            if (q_valid && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               found_in = 1'b0;
               full_in  = 1'b0;
               unique case (q_cmd.kind) inside
                  pfba_pkg::K_SET, pfba_pkg::K_CLR: begin
                     word_in  = q_cmd.first_word;
                     state_in = pfba_pkg::ST_RUN_READ;
                  end
                  pfba_pkg::K_REQ: begin
                     word_in  = '0;
                     state_in = pfba_pkg::ST_SRCH_READ;
                  end
                  default: begin
                     state_in = pfba_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         pfba_pkg::ST_RUN_READ: begin
            state_in = pfba_pkg::ST_RUN_WRITE;
         end
         pfba_pkg::ST_RUN_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = (cmd_ff.kind == pfba_pkg::K_SET) ? (rdata_ff | run_mask) :
                                                           (rdata_ff & ~run_mask);
            if (word_ff == cmd_ff.last_word) begin
               state_in = pfba_pkg::ST_FINISH;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = pfba_pkg::ST_RUN_READ;
            end
         end
         pfba_pkg::ST_SRCH_READ: begin
            state_in = pfba_pkg::ST_SRCH_CHECK;
         end
         pfba_pkg::ST_SRCH_CHECK: begin
            if (rdata_ff != pfba_pkg::ALL_ONES) begin
               mem_we     = 1'b1;
               mem_wdata  = rdata_ff | (W'(1) << free_bit);
               granted_in = pfba_pkg::FRAME_W'({word_ff, free_bit});
               found_in   = 1'b1;
               state_in   = pfba_pkg::ST_FINISH;
            end else if (word_ff == SRCH_LAST) begin
               full_in  = 1'b1;
               state_in = pfba_pkg::ST_FINISH;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = pfba_pkg::ST_SRCH_READ;
            end
         end
         pfba_pkg::ST_FINISH: begin
            case (cmd_ff.cnt)
               pfba_pkg::CNT_LOCK: begin
                  free_in = sat_sub(free_ff, cmd_ff.count);
                  used_in = sat_add(used_ff, cmd_ff.count, memory_pages);
               end
               pfba_pkg::CNT_UNLOCK: begin
                  free_in = sat_add(free_ff, cmd_ff.count, memory_pages);
                  used_in = sat_sub(used_ff, cmd_ff.count);
               end
               pfba_pkg::CNT_RESV: begin
                  free_in = sat_sub(free_ff, cmd_ff.count);
                  resv_in = sat_add(resv_ff, cmd_ff.count, memory_pages);
               end
               pfba_pkg::CNT_UNRESV: begin
                  free_in = sat_add(free_ff, cmd_ff.count, memory_pages);
                  resv_in = sat_sub(resv_ff, cmd_ff.count);
               end
               pfba_pkg::CNT_REQ: begin
                  if (found_ff) begin
                     free_in = sat_sub(free_ff, CW'(1));
                     used_in = sat_add(used_ff, CW'(1), memory_pages);
                  end
               end
               default: begin
               end
            endcase
            rsp_valid_in = 1'b1;
            rsp_full_in  = full_ff;
            rsp_data_in  = {5'b0, resv_in, used_in, free_in,
                            found_ff ? granted_ff : pfba_pkg::FRAME_W'(0)};
            state_in     = pfba_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfba_pkg::ST_CLEAR;
         word_ff      <= '0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
         free_ff      <= pfba_pkg::MEM_PAGES_RESET;
         used_ff      <= '0;
         resv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         found_ff     <= found_in;
         full_ff      <= full_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         resv_ff      <= resv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      granted_ff  <= granted_in;
      rsp_data_ff <= rsp_data_in;
      rsp_full_ff <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[word_ff] <= mem_wdata;
      end
      rdata_ff <= mem[word_ff];
   end

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfba_pkg::ST_CLEAR) |-> !q_pop)
      else $error("command taken during the clearing pass");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pfba_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   a_run_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfba_pkg::ST_RUN_WRITE) |->
         (word_ff >= cmd_ff.first_word && word_ff <= cmd_ff.last_word))
      else $error("run write outside its word range");

   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_data_ff[pfba_pkg::FRAME_W-1:0] == '0))
      else $error("full result carries a granted frame");

endmodule

// ----- src/page_frame_bitmap_allocator_unit.sv -----
// Top level of the page frame bitmap allocator: register port, front end, queue, back end.
// Depends on pfba_pkg, pfba_front, pfba_queue and pfba_back.
//
//   channel   direction   payload
//   req_*     in          tuser: opcode[2:0]; tdata: start_frame[15:0], page_count[32:16]
//   rsp_*     out         tuser: full_res; tdata: granted_frame[15:0], free_pages[32:16],
//                         used_pages[49:33], reserved_pages[66:50]
//   csr_*     in/out      memory_pages at byte address 0
//
// After reset the bitmap is cleared one word a cycle, all 1024 words, while req_tready is low.
// A run over W bitmap words does one memory read and one write per word.
// A request reads and checks words in turn, up to 1024 of them, until one holds a clear frame.
// Unused opcodes and empty runs skip the memory; the result shows in the cycle after the finish step.
// The queue holds two commands, so the front keeps accepting while a result waits, until it is full.
module page_frame_bitmap_allocator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfba_pkg::REQ_DATA_W-1:0]   req_tdata,  // start_frame, page_count
   input  logic [pfba_pkg::OPCODE_W-1:0]     req_tuser,  // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfba_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // granted_frame, free, used, reserved
   output logic                              rsp_tuser,  // full_res
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pfba_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [pfba_pkg::COUNT_W-1:0] mem_pages_ff, mem_pages_in;
   logic                         csr_hit;

   logic              q_push, q_full, q_pop, q_valid, clear_busy;
   pfba_pkg::cmd_type push_cmd, pop_cmd;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == pfba_pkg::CSR_MEMORY_PAGES);
   assign csr_prdata = csr_hit ? {15'b0, mem_pages_ff} : 32'b0;

   always_comb begin
      mem_pages_in = mem_pages_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         mem_pages_in = csr_pwdata[pfba_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_pages_ff <= pfba_pkg::MEM_PAGES_RESET;
      end else begin
         mem_pages_ff <= mem_pages_in;
      end
   end

   pfba_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   pfba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_cmd   (pop_cmd),
      .not_empty (q_valid)
   );

   pfba_back u_back (
      .clock        (clock),
      .reset        (reset),
      .memory_pages (mem_pages_ff),
      .q_valid      (q_valid),
      .q_cmd        (pop_cmd),
      .q_pop        (q_pop),
      .clear_busy   (clear_busy),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for page_frame_bitmap_allocator_unit: directed rows, then random runs.
// It depends on pfba_pkg and the allocator RTL only. A local bitmap predictor supplies the
// expected words of all but the typed directed rows.
`timescale 1ns / 1ps

module tb_top;

   localparam int RAND_PER_PHASE = 216;
   localparam int PHASES         = 5;
   localparam int LONG_STALL     = 400;
   localparam int TAIL_CYCLES    = 64;
   // Slowest legal item: a full-store run or search, plus the longest gaps on both sides.
   localparam longint unsigned CYCLE_LIMIT =
      3 * (longint'(RAND_PER_PHASE * PHASES + 40) * (2 + 2 * pfba_pkg::FRAME_WORDS + 2 + 40))
      + 4 * pfba_pkg::FRAME_WORDS + 4 * LONG_STALL;
   localparam int SCAN_FRAMES =
      (pfba_pkg::TOTAL_FRAMES < 65536) ? pfba_pkg::TOTAL_FRAMES : 65536;

   localparam logic [pfba_pkg::OPCODE_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [pfba_pkg::OPCODE_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [pfba_pkg::OPCODE_W-1:0] OP_UNUSED_HI  = 3'd7;
   localparam logic [pfba_pkg::CSR_ADDR_W-1:0] PAGES_ADDR = {pfba_pkg::CSR_MEMORY_PAGES, 2'b00};
   // Byte address of a register index that the block does not implement.
   localparam logic [pfba_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   typedef struct packed {
      logic [15:0] frame;
      logic        full;
      logic [16:0] free;
      logic [16:0] used;
      logic [16:0] resv;
   } frame_result_type;

   typedef struct packed {
      logic [pfba_pkg::OPCODE_W-1:0] op;
      logic [15:0]                   start;
      logic [16:0]                   count;
      bit                            typed;
      frame_result_type              want;
   } step_row_type;

   // Rows with typed results can be worked out by hand from the reset state.
   step_row_type directed_rows [23] = '{
      '{pfba_pkg::OP_REQUEST, 16'd0, 17'd0, 1'b1, '{16'd0, 1'b0, 17'd65535, 17'd1, 17'd0}},
      '{pfba_pkg::OP_REQUEST, 16'd0, 17'd0, 1'b1, '{16'd1, 1'b0, 17'd65534, 17'd2, 17'd0}},
      '{pfba_pkg::OP_LOCK, 16'd5, 17'd0, 1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
      '{OP_UNUSED_LO, 16'd0, 17'd0, 1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
      '{OP_UNUSED_HI, 16'd65535, 17'd65536, 1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
      '{pfba_pkg::OP_LOCK, 16'd65535, 17'd65536, 1'b1,
        '{16'd0, 1'b0, 17'd0, 17'd65536, 17'd0}},
      '{pfba_pkg::OP_UNLOCK, 16'd0, 17'd65536, 1'b1,
        '{16'd0, 1'b0, 17'd65536, 17'd0, 17'd0}},
      '{pfba_pkg::OP_RESERVE, 16'd0, 17'd65536, 1'b1,
        '{16'd0, 1'b0, 17'd0, 17'd0, 17'd65536}},
      '{pfba_pkg::OP_REQUEST, 16'd0, 17'd0, 1'b1, '{16'd0, 1'b1, 17'd0, 17'd0, 17'd65536}},
      '{pfba_pkg::OP_UNRESERVE, 16'd65535, 17'd1, 1'b1,
        '{16'd0, 1'b0, 17'd1, 17'd0, 17'd65535}},
      '{pfba_pkg::OP_REQUEST, 16'd0, 17'd0, 1'b1,
        '{16'd65535, 1'b0, 17'd0, 17'd1, 17'd65535}},
      '{pfba_pkg::OP_REQUEST, 16'd0, 17'd0, 1'b1, '{16'd0, 1'b1, 17'd0, 17'd1, 17'd65535}},
      '{pfba_pkg::OP_UNRESERVE, 16'd0, 17'd65536, 1'b1,
        '{16'd0, 1'b0, 17'd65536, 17'd1, 17'd0}},
      '{pfba_pkg::OP_LOCK,      16'd100,   17'd40,    1'b0, '0},
      '{pfba_pkg::OP_RESERVE,   16'd63,    17'd2,     1'b0, '0},
      '{pfba_pkg::OP_REQUEST,   16'd0,     17'd0,     1'b0, '0},
      '{pfba_pkg::OP_UNLOCK,    16'd120,   17'd5,     1'b0, '0},
      '{pfba_pkg::OP_REQUEST,   16'd0,     17'd0,     1'b0, '0},
      '{pfba_pkg::OP_LOCK,      16'd65530, 17'd100,   1'b0, '0},
      '{pfba_pkg::OP_UNRESERVE, 16'd64,    17'd1,     1'b0, '0},
      '{pfba_pkg::OP_UNRESERVE, 16'd0,     17'd3,     1'b0, '0},
      '{OP_UNUSED_MID,          16'd32768, 17'd65535, 1'b0, '0},
      '{pfba_pkg::OP_UNLOCK,    16'd0,     17'd65535, 1'b0, '0}
   };

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [pfba_pkg::REQ_DATA_W-1:0] req_tdata   = '0;  // start_frame[15:0], page_count[32:16]
   logic [pfba_pkg::OPCODE_W-1:0]   req_tuser   = '0;  // opcode[2:0]
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   // granted_frame, free_pages, used_pages, reserved_pages
   logic [pfba_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;  // full_res
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [pfba_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   // Local copy of the allocator state.
   bit [pfba_pkg::BITS_PER_WORD-1:0] shadow_map [pfba_pkg::FRAME_WORDS];
   int unsigned shadow_free  = 65536;
   int unsigned shadow_used  = 0;
   int unsigned shadow_resv  = 0;
   int unsigned shadow_pages = 65536;

   frame_result_type pending_results [$];
   int unsigned errors = 0;
   int unsigned words_sent = 0;
   int unsigned results_seen = 0;
   int unsigned grants_seen = 0;
   int unsigned fulls_seen = 0;
   int unsigned settings_written = 0;
   bit quiet_tail = 1'b0;
   int unsigned stall_asked = 0;
   int unsigned stall_taken = 0;
   int unsigned sink_wait = 0;
   longint unsigned cycle_count = 0;

   page_frame_bitmap_allocator_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned sat_down(int unsigned c, int unsigned n);
      return (n >= c) ? 0 : c - n;
   endfunction

   function automatic int unsigned sat_up(int unsigned c, int unsigned n);
      if (c >= shadow_pages) return c;
      return (c + n > shadow_pages) ? shadow_pages : c + n;
   endfunction

   function automatic void mark_run(int unsigned first, int unsigned n, bit value);
      for (int unsigned i = 0; i < n; i++) begin
         if (first + i >= pfba_pkg::TOTAL_FRAMES) break;
         shadow_map[(first + i) / pfba_pkg::BITS_PER_WORD]
                   [(first + i) % pfba_pkg::BITS_PER_WORD] = value;
      end
   endfunction

   function automatic frame_result_type apply_frame_op(logic [pfba_pkg::OPCODE_W-1:0] op,
                                                       int unsigned start, int unsigned count);
      frame_result_type r;
      bit found;
      int unsigned slot;
      r = '0;
      found = 1'b0;
      slot = 0;
      case (op)
         pfba_pkg::OP_LOCK: begin
            mark_run(start, count, 1'b1);
            shadow_free = sat_down(shadow_free, count);
            shadow_used = sat_up(shadow_used, count);
         end
         pfba_pkg::OP_UNLOCK: begin
            mark_run(start, count, 1'b0);
            shadow_free = sat_up(shadow_free, count);
            shadow_used = sat_down(shadow_used, count);
         end
         pfba_pkg::OP_RESERVE: begin
            mark_run(start, count, 1'b1);
            shadow_free = sat_down(shadow_free, count);
            shadow_resv = sat_up(shadow_resv, count);
         end
         pfba_pkg::OP_UNRESERVE: begin
            mark_run(start, count, 1'b0);
            shadow_free = sat_up(shadow_free, count);
            shadow_resv = sat_down(shadow_resv, count);
         end
         pfba_pkg::OP_REQUEST: begin
            for (int w = 0; w < (SCAN_FRAMES + 63) / 64 && !found; w++) begin
               if (shadow_map[w] != pfba_pkg::ALL_ONES) begin
                  for (int b = 0; b < pfba_pkg::BITS_PER_WORD && !found; b++) begin
                     if (w * 64 + b < SCAN_FRAMES && !shadow_map[w][b]) begin
                        found = 1'b1;
                        slot = w * 64 + b;
                     end
                  end
               end
            end
            if (found) begin
               mark_run(slot, 1, 1'b1);
               shadow_free = sat_down(shadow_free, 1);
               shadow_used = sat_up(shadow_used, 1);
               r.frame = slot[15:0];
            end else begin
               r.full = 1'b1;
            end
         end
         default: ;
      endcase
      r.free = shadow_free[16:0];
      r.used = shadow_used[16:0];
      r.resv = shadow_resv[16:0];
      return r;
   endfunction

   task automatic send_word(input logic [pfba_pkg::OPCODE_W-1:0] op, input logic [15:0] start,
                            input logic [16:0] count, input bit typed,
                            input frame_result_type typed_want);
      frame_result_type want;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, count, start};
      do @(posedge clock); while (!req_tready);
      want = apply_frame_op(op, start, count);
      pending_results.push_back(typed ? typed_want : want);
      words_sent++;
   endtask

   task automatic csr_cycle(input logic wr, input logic [pfba_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%t rsp %s: expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Result sink: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (sink_wait != 0) begin
         sink_wait <= sink_wait - 1;
      end else if (stall_taken != stall_asked) begin
         stall_taken <= stall_asked;
         sink_wait   <= LONG_STALL - 1;
         rsp_tready  <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         sink_wait  <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) fulls_seen++;
         else if (rsp_tdata[15:0] != 0) grants_seen++;
         if (pending_results.size() == 0) begin
            $display("%t rsp word with nothing expected: full %0d, data %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("granted_frame", want.frame, rsp_tdata[15:0]);
            check_field("full_res", want.full, rsp_tuser);
            check_field("free_pages", want.free, rsp_tdata[32:16]);
            check_field("used_pages", want.used, rsp_tdata[49:33]);
            check_field("reserved_pages", want.resv, rsp_tdata[66:50]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%t timeout with %0d words outstanding", $time, pending_results.size());
         $display("page_frame_bitmap_allocator_unit: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned phase_pages [PHASES];
      int unsigned pick;
      logic [pfba_pkg::OPCODE_W-1:0] op;
      logic [15:0] start;
      logic [16:0] count;
      logic [31:0] rdata;
      phase_pages = '{65536, 1, 0, 300, 65536};
      phase_pages[2] = $urandom_range(2, 65535);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASES; p++) begin
         while (pending_results.size() != 0) @(posedge clock);
         csr_cycle(1'b1, PAGES_ADDR, phase_pages[p], rdata);
         shadow_pages = phase_pages[p];
         settings_written++;
         // A write to an unimplemented index must leave memory_pages alone.
         if (p == 3) csr_cycle(1'b1, SPARE_ADDR, $urandom, rdata);
         csr_cycle(1'b0, PAGES_ADDR, '0, rdata);
         if (rdata != shadow_pages) begin
            $display("%t memory_pages readback: expected %0d, got %0d",
                     $time, shadow_pages, rdata);
            errors++;
         end
         if (p == PHASES - 1) quiet_tail = 1'b1;
         if (p == 2) stall_asked++;
         if (p == 0) begin
            foreach (directed_rows[i])
               send_word(directed_rows[i].op, directed_rows[i].start, directed_rows[i].count,
                         directed_rows[i].typed, directed_rows[i].want);
         end
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) op = pfba_pkg::OP_REQUEST;
            else if (pick < 45) op = pfba_pkg::OP_LOCK;
            else if (pick < 65) op = pfba_pkg::OP_UNLOCK;
            else if (pick < 80) op = pfba_pkg::OP_RESERVE;
            else if (pick < 95) op = pfba_pkg::OP_UNRESERVE;
            else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            // Half the runs land low in the map, where requests search.
            start = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 75) count = 17'($urandom_range(0, 130));
            else if (pick < 95) count = 17'($urandom_range(131, 2000));
            else if (pick < 98) count = 17'($urandom_range(2001, 65535));
            else count = 17'd65536;
            send_word(op, start, count, 1'b0, '0);
         end
         req_tvalid <= 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d command words over %0d memory_pages settings, one long sink stall.",
               words_sent, settings_written);
      $display("Checked %0d result words: %0d nonzero grants, %0d full replies.",
               results_seen, grants_seen, fulls_seen);
      if (errors == 0) begin
         $display("page_frame_bitmap_allocator_unit: match");
      end else begin
         $display("page_frame_bitmap_allocator_unit: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pfba_pkg.sv
src/pfba_front.sv
src/pfba_queue.sv
src/pfba_back.sv
src/page_frame_bitmap_allocator_unit.sv
tb/sv/tb_top.sv
